// ===== hdl/prdm_pkg.sv =====
// Shared types and constants of the PWM signal-strength duty monitor.
// Used by the channel interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package prdm_pkg;

   localparam int CAPTURE_WIDTH_DEFAULT = 16;

   localparam int FIELD_W     = 16;
   localparam int TIME_W      = 32;
   localparam int DUTY_W      = 10;
   localparam int LEVEL_W     = 8;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;

   // Duty is scaled to thousandths; the quotient never exceeds 1000, so ten bits suffice.
   localparam int DUTY_SCALE = 1000;
   localparam int QUOT_BITS  = 10;
   localparam int STEP_W     = $clog2(QUOT_BITS);

   // Rounded division by ten of a value below 1029 as a multiply and shift.
   localparam int ROUND_BIAS  = 5;
   localparam int RECIP_TEN   = 205;
   localparam int RECIP_SHIFT = 11;
   localparam int LVL_SUM_W   = DUTY_W + 1;
   localparam int LVL_PROD_W  = LVL_SUM_W + 8;

   localparam logic [FIELD_W-1:0] MIN_PERIOD_RESET    = 16'd800;
   localparam logic [FIELD_W-1:0] MAX_PERIOD_RESET    = 16'd1200;
   localparam logic [TIME_W-1:0]  STALE_TIMEOUT_RESET = 32'd4500;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_CAPTURE = 2'd1,
      ACT_READ    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_PERIOD    = 2'd0,
      CSR_MAX_PERIOD    = 2'd1,
      CSR_STALE_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic tick;
      logic capture;
      logic start;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

endpackage

// ===== hdl/prdm_req_if.sv =====
// Request channel: one word is a tick, a capture or a read request.
// Depends on prdm_pkg.
interface prdm_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     action;
   logic [prdm_pkg::FIELD_W-1:0]   period_in;
   logic [prdm_pkg::FIELD_W-1:0]   high_in;

   modport source (output valid, output action, output period_in, output high_in,
                   input ready);
   modport sink   (input valid, input action, input period_in, input high_in,
                   output ready);
endinterface

// ===== hdl/prdm_rsp_if.sv =====
// Response channel: one word per read request.
// Depends on prdm_pkg.
interface prdm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [prdm_pkg::TIME_W-1:0]         age_ms;
   logic [prdm_pkg::DUTY_W-1:0]         duty_ppt;
   logic                                fresh;
   logic signed [prdm_pkg::LEVEL_W-1:0] level_dbm;
   logic [prdm_pkg::TIME_W-1:0]         captures;

   modport source (output valid, output age_ms, output duty_ppt, output fresh,
                   output level_dbm, output captures, input ready);
   modport sink   (input valid, input age_ms, input duty_ppt, input fresh,
                   input level_dbm, input captures, output ready);
endinterface

// ===== hdl/prdm_ctrl.sv =====
// Controller of the duty monitor: accepts request words and sequences the
// divider and the response register. Depends on prdm_pkg.
module prdm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_action,
   output logic                 req_ready,
   input  prdm_pkg::status_type status,
   output prdm_pkg::cmd_type    cmd
);
   import prdm_pkg::*;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (action_type'(req_action))
                  ACT_TICK:    cmd.tick = 1'b1;
                  ACT_CAPTURE: cmd.capture = 1'b1;
                  ACT_READ: begin
                     cmd.start = 1'b1;
                     step_in   = '0;
                     state_in  = ST_DIVIDE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (step_ff == STEP_W'(QUOT_BITS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // Hold the result until the response register has room.
            if (!status.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hdl/prdm_dp.sv =====
// Datapath of the duty monitor: settings, kept capture, time base, restoring
// divider for the duty and the response register. Depends on prdm_pkg.
module prdm_dp #(
   parameter int CAPTURE_WIDTH = prdm_pkg::CAPTURE_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [prdm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [prdm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [prdm_pkg::FIELD_W-1:0]        req_period_in,
   input  logic [prdm_pkg::FIELD_W-1:0]        req_high_in,
   input  prdm_pkg::cmd_type                   cmd,
   output prdm_pkg::status_type                status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [prdm_pkg::TIME_W-1:0]         rsp_age_ms,
   output logic [prdm_pkg::DUTY_W-1:0]         rsp_duty_ppt,
   output logic                                rsp_fresh,
   output logic signed [prdm_pkg::LEVEL_W-1:0] rsp_level_dbm,
   output logic [prdm_pkg::TIME_W-1:0]         rsp_captures
);
   import prdm_pkg::*;

   // Captures are masked to CAPTURE_WIDTH bits, and the fields carry 16 at most.
   localparam int KEEP_W = (CAPTURE_WIDTH < FIELD_W) ? CAPTURE_WIDTH : FIELD_W;
   localparam int DIVD_W = KEEP_W + QUOT_BITS;
   localparam int DSR_W  = KEEP_W + QUOT_BITS - 1;

   logic [FIELD_W-1:0] min_period_ff, max_period_ff;
   logic [TIME_W-1:0]  stale_timeout_ff;
   logic [TIME_W-1:0]  now_ff, last_time_ff, total_ff;
   logic [KEEP_W-1:0]  kept_period_ff, kept_high_ff;
   logic               have_ff;

   logic [DIVD_W-1:0]    rem_ff;
   logic [DSR_W-1:0]     dsr_ff;
   logic [QUOT_BITS-1:0] quo_ff;

   logic [KEEP_W-1:0]      cap_period, cap_high;
   logic                   cap_keep;
   logic [DIVD_W-1:0]      dividend;
   logic [TIME_W-1:0]      age;
   logic [DUTY_W-1:0]      duty;
   logic                   fresh;
   logic [LVL_SUM_W-1:0]   lvl_sum;
   logic [LVL_PROD_W-1:0]  lvl_prod;
   logic [LEVEL_W-1:0]     lvl_mag;

   function automatic logic in_window(input logic [FIELD_W-1:0] p,
                                      input logic [FIELD_W-1:0] lo,
                                      input logic [FIELD_W-1:0] hi);
      return (p >= lo) && (p <= hi);
   endfunction

   assign cap_period = req_period_in[KEEP_W-1:0];
   assign cap_high   = req_high_in[KEEP_W-1:0];
   assign cap_keep   = in_window(FIELD_W'(cap_period), min_period_ff, max_period_ff)
                       && (cap_high <= cap_period);

   // Rounded duty: (high * 1000 + period / 2) / period.
   assign dividend = DIVD_W'(DIVD_W'(kept_high_ff) * DIVD_W'(DUTY_SCALE))
                     + DIVD_W'(kept_period_ff >> 1);

   assign age   = now_ff - last_time_ff;
   assign duty  = (kept_period_ff == '0) ? '0 : DUTY_W'(quo_ff);
   assign fresh = have_ff
                  && in_window(FIELD_W'(kept_period_ff), min_period_ff, max_period_ff)
                  && (age <= stale_timeout_ff);

   assign lvl_sum  = LVL_SUM_W'(duty) + LVL_SUM_W'(ROUND_BIAS);
   assign lvl_prod = LVL_PROD_W'(lvl_sum) * LVL_PROD_W'(RECIP_TEN);
   assign lvl_mag  = LEVEL_W'(lvl_prod >> RECIP_SHIFT);

   assign status.out_full = rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff    <= MIN_PERIOD_RESET;
         max_period_ff    <= MAX_PERIOD_RESET;
         stale_timeout_ff <= STALE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_PERIOD:    min_period_ff    <= csr_wdata[FIELD_W-1:0];
            CSR_MAX_PERIOD:    max_period_ff    <= csr_wdata[FIELD_W-1:0];
            CSR_STALE_TIMEOUT: stale_timeout_ff <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= '0;
         last_time_ff   <= '0;
         total_ff       <= '0;
         kept_period_ff <= '0;
         kept_high_ff   <= '0;
         have_ff        <= 1'b0;
      end else begin
         if (cmd.tick) begin
            now_ff <= now_ff + 1'b1;
         end
         if (cmd.capture && cap_keep) begin
            kept_period_ff <= cap_period;
            kept_high_ff   <= cap_high;
            last_time_ff   <= now_ff;
            total_ff       <= total_ff + 1'b1;
            have_ff        <= 1'b1;
         end
      end
   end

   // Restoring division, one quotient bit per step, most significant first.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= dividend;
         dsr_ff <= {kept_period_ff, {(QUOT_BITS - 1){1'b0}}};
         quo_ff <= '0;
      end else if (cmd.step) begin
         if (rem_ff >= DIVD_W'(dsr_ff)) begin
            rem_ff <= rem_ff - DIVD_W'(dsr_ff);
            quo_ff <= {quo_ff[QUOT_BITS-2:0], 1'b1};
         end else begin
            quo_ff <= {quo_ff[QUOT_BITS-2:0], 1'b0};
         end
         dsr_ff <= dsr_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_age_ms    <= age;
         rsp_duty_ppt  <= duty;
         rsp_fresh     <= fresh;
         rsp_level_dbm <= fresh ? -$signed(lvl_mag) : '0;
         rsp_captures  <= total_ff;
      end
   end

endmodule

// ===== hdl/pwm_rssi_duty_monitor.sv =====
// PWM signal-strength duty monitor, top level.
// Ticks and captures are accepted while the controller is idle and leave it idle.
// A read holds the request channel: it is accepted as the divider is loaded, then
// ten restoring divide steps (one quotient bit each) run, and then the response
// register is loaded once no older word still waits there.
// Synchronous active-high reset restores the default window and timeout and
// clears the time base, the kept capture and the capture count.
module pwm_rssi_duty_monitor #(
   parameter int CAPTURE_WIDTH = prdm_pkg::CAPTURE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   prdm_req_if.sink                         req_chan,
   prdm_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [prdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [prdm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import prdm_pkg::*;

   cmd_type    cmd;
   status_type status;

   prdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   prdm_dp #(
      .CAPTURE_WIDTH (CAPTURE_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_period_in      (req_chan.period_in),
      .req_high_in        (req_chan.high_in),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_age_ms         (rsp_chan.age_ms),
      .rsp_duty_ppt       (rsp_chan.duty_ppt),
      .rsp_fresh          (rsp_chan.fresh),
      .rsp_level_dbm      (rsp_chan.level_dbm),
      .rsp_captures       (rsp_chan.captures)
   );

endmodule

// ===== test/tb_pwm_rssi_duty_monitor.sv =====
// Self-checking testbench for the PWM signal-strength duty monitor.
// It drives ticks, captures and reads through the request channel, predicts each reading
// word in step with the block, and checks it. Needs prdm_pkg, both channel interfaces and the top.
module tb_pwm_rssi_duty_monitor;
   import prdm_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int RUN_LIMIT_CYCLES = 1_000_000;
   localparam int DRAIN_LIMIT      = 4000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_CYCLES = 240;
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 180;
   localparam int TENTHS           = 10;
   localparam logic [63:0] CAPTURE_MASK = (64'd1 << CAPTURE_WIDTH_DEFAULT) - 64'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0]         age_ms;
      logic [DUTY_W-1:0]         duty_ppt;
      logic                      fresh;
      logic signed [LEVEL_W-1:0] level_dbm;
      logic [TIME_W-1:0]         captures;
   } reading_type;

   typedef struct packed {
      action_type         act;
      logic [FIELD_W-1:0] period;
      logic [FIELD_W-1:0] high;
      logic               pinned;
      reading_type        want;
   } plan_row_type;

   localparam reading_type NO_READING = '0;

   // Readings are typed in only where the value is obvious; the rest come from the predictor.
   localparam plan_row_type PLAN [23] = '{
      '{ACT_READ,    16'd0,     16'd0,     1'b1, '{32'd0, 10'd0, 1'b0, 8'sd0, 32'd0}},
      '{ACT_NONE,    16'hFFFF,  16'hFFFF,  1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b1, '{32'd0, 10'd0, 1'b0, 8'sd0, 32'd0}},
      '{ACT_TICK,    16'd0,     16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd799,   16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd1201,  16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd1000,  16'd1001,  1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b1, '{32'd1, 10'd0, 1'b0, 8'sd0, 32'd0}},
      '{ACT_CAPTURE, 16'd800,   16'd800,   1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b1, '{32'd0, 10'd1000, 1'b1, -8'sd100, 32'd1}},
      '{ACT_TICK,    16'd0,     16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd1200,  16'd0,     1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b1, '{32'd0, 10'd0, 1'b1, 8'sd0, 32'd2}},
      '{ACT_CAPTURE, 16'd1000,  16'd333,   1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd1000,  16'd5,     1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd999,   16'd1,     1'b0, NO_READING},
      '{ACT_TICK,    16'd0,     16'd0,     1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b0, NO_READING},
      '{ACT_CAPTURE, 16'hFFFF,  16'hFFFF,  1'b0, NO_READING},
      '{ACT_CAPTURE, 16'd1001,  16'd500,   1'b0, NO_READING},
      '{ACT_READ,    16'd0,     16'd0,     1'b0, NO_READING}
   };

   localparam logic [FIELD_W-1:0] PHASE_MIN [PHASES] = '{
      16'd0, 16'd800, 16'd1200, 16'd0, 16'd65535, 16'd500, 16'd900, 16'd0};
   localparam logic [FIELD_W-1:0] PHASE_MAX [PHASES] = '{
      16'd65535, 16'd1200, 16'd800, 16'd0, 16'd65535, 16'd4000, 16'd1100, 16'd0};
   localparam logic [TIME_W-1:0] PHASE_STALE [PHASES] = '{
      32'hFFFF_FFFF, 32'd4500, 32'd4500, 32'd0, 32'd3, 32'd25, 32'd1, 32'd0};

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   prdm_req_if req_bus ();
   prdm_rsp_if rsp_bus ();

   pwm_rssi_duty_monitor u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Predictor state, kept in step with the block at every accepted word.
   logic [FIELD_W-1:0] win_lo      = MIN_PERIOD_RESET;
   logic [FIELD_W-1:0] win_hi      = MAX_PERIOD_RESET;
   logic [TIME_W-1:0]  stale_ms    = STALE_TIMEOUT_RESET;
   logic [TIME_W-1:0]  now_ms      = '0;
   logic [FIELD_W-1:0] kept_period = '0;
   logic [FIELD_W-1:0] kept_high   = '0;
   logic [TIME_W-1:0]  kept_at_ms  = '0;
   logic [TIME_W-1:0]  kept_count  = '0;
   logic               kept_valid  = 1'b0;

   reading_type expected_readings [$];

   bit          pin_on;
   reading_type pin_word;
   bit          calm;
   int          hold_requests;
   int          mismatches   = 0;
   int          tick_words   = 0;
   int          capture_words = 0;
   int          read_words   = 0;
   int          readings_checked = 0;

   function automatic bit window_holds(input logic [63:0] period);
      return period >= 64'(win_lo) && period <= 64'(win_hi);
   endfunction

   function automatic bit predict_reading(input action_type act,
                                          input logic [FIELD_W-1:0] period_in,
                                          input logic [FIELD_W-1:0] high_in,
                                          output reading_type rd);
      logic [63:0] p;
      logic [63:0] h;
      logic [TIME_W-1:0] age;
      logic [DUTY_W-1:0] duty;
      int unsigned rounded;
      bit fresh;
      rd = '0;
      case (act)
         ACT_TICK: begin
            now_ms = now_ms + 32'd1;
         end
         ACT_CAPTURE: begin
            p = 64'(period_in) & CAPTURE_MASK;
            h = 64'(high_in) & CAPTURE_MASK;
            if (window_holds(p) && h <= p) begin
               kept_period = FIELD_W'(p);
               kept_high   = FIELD_W'(h);
               kept_at_ms  = now_ms;
               kept_count  = kept_count + 32'd1;
               kept_valid  = 1'b1;
            end
         end
         ACT_READ: begin
            age = now_ms - kept_at_ms;
            if (kept_period == '0)
               duty = '0;
            else
               duty = DUTY_W'((64'(kept_high) * DUTY_SCALE + 64'(kept_period) / 2)
                              / 64'(kept_period));
            fresh = kept_valid && window_holds(64'(kept_period)) && age <= stale_ms;
            rounded = (int'(duty) + ROUND_BIAS) / TENTHS;
            rd.age_ms         = age;
            rd.duty_ppt       = duty;
            rd.fresh          = fresh;
            rd.level_dbm      = fresh ? LEVEL_W'(32'd0 - rounded) : '0;
            rd.captures       = kept_count;
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      reading_type want;
      reading_type predicted;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_readings.size() == 0) begin
               $error("reading word with none expected: age_ms %0d, captures %0d",
                      rsp_bus.age_ms, rsp_bus.captures);
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               check_field("age_ms", 64'(want.age_ms), 64'(rsp_bus.age_ms));
               check_field("duty_ppt", 64'(want.duty_ppt), 64'(rsp_bus.duty_ppt));
               check_field("fresh", 64'(want.fresh), 64'(rsp_bus.fresh));
               check_field("level_dbm", 64'(want.level_dbm), 64'(rsp_bus.level_dbm));
               check_field("captures", 64'(want.captures), 64'(rsp_bus.captures));
               readings_checked++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_PERIOD:    win_lo   = csr_wdata[FIELD_W-1:0];
               CSR_MAX_PERIOD:    win_hi   = csr_wdata[FIELD_W-1:0];
               CSR_STALE_TIMEOUT: stale_ms = csr_wdata;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            case (action_type'(req_bus.action))
               ACT_TICK:    tick_words++;
               ACT_CAPTURE: capture_words++;
               ACT_READ:    read_words++;
               default: ;
            endcase
            if (predict_reading(action_type'(req_bus.action), req_bus.period_in,
                                req_bus.high_in, predicted))
               expected_readings.push_back(pin_on ? pin_word : predicted);
         end
      end
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: short random stalls, and one long hold-off on request.
   initial begin
      int gap_left;
      int hold_left;
      int holds_served;
      gap_left = 0;
      hold_left = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               gap_left = pick_gap(1'b0);
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input action_type act, input logic [FIELD_W-1:0] period,
                            input logic [FIELD_W-1:0] high, input bit pinned,
                            input reading_type want);
      int gap;
      gap = pick_gap(calm);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.action    = act;
      req_bus.period_in = period;
      req_bus.high_in   = high;
      pin_on            = pinned;
      pin_word          = want;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
   endtask

   // Waits, up to DRAIN_LIMIT, for every reading to come back, then lets any tick or capture finish.
   task automatic settle_block();
      int waited;
      waited = 0;
      req_bus.valid = 1'b0;
      while (expected_readings.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      #(CLOCK_PERIOD * RUN_LIMIT_CYCLES);
      $display("pwm_rssi_duty_monitor verification failed");
      $finish;
   end

   initial begin
      int ph;
      int n;
      int r;
      action_type act;
      logic [FIELD_W-1:0] p;
      logic [FIELD_W-1:0] h;
      logic [FIELD_W-1:0] lo;
      logic [FIELD_W-1:0] hi;
      logic [TIME_W-1:0] stale;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_MIN_PERIOD;
      csr_wdata         = '0;
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_TICK;
      req_bus.period_in = '0;
      req_bus.high_in   = '0;
      pin_on            = 1'b0;
      pin_word          = '0;
      calm              = 1'b0;
      hold_requests     = 0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      foreach (PLAN[i])
         send_word(PLAN[i].act, PLAN[i].period, PLAN[i].high, PLAN[i].pinned, PLAN[i].want);

      for (ph = 0; ph < PHASES; ph++) begin
         settle_block();
         lo    = PHASE_MIN[ph];
         hi    = PHASE_MAX[ph];
         stale = PHASE_STALE[ph];
         if (ph == PHASES - 1) begin
            p  = FIELD_W'($urandom);
            h  = FIELD_W'($urandom);
            lo = (p < h) ? p : h;
            hi = (p < h) ? h : p;
            stale = $urandom_range(0, 300);
         end
         write_reg(CSR_MIN_PERIOD, CSR_DATA_W'(lo));
         write_reg(CSR_MAX_PERIOD, CSR_DATA_W'(hi));
         write_reg(CSR_STALE_TIMEOUT, stale);
         // An unused index must leave every register alone.
         if (ph == 2)
            write_reg(CSR_SPARE_INDEX, 32'hFFFF_FFFF);
         csr_we = 1'b0;
         calm = (ph == 3 || ph == 6);
         if (ph == 1)
            hold_requests++;

         // The first read of a phase sees the old capture against the new window.
         send_word(ACT_READ, '0, '0, 1'b0, NO_READING);
         n = 0;
         while (n < RANDOM_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 40)
               act = ACT_TICK;
            else if (r < 70)
               act = ACT_CAPTURE;
            else if (r < 95)
               act = ACT_READ;
            else
               act = ACT_NONE;
            p = FIELD_W'($urandom);
            h = FIELD_W'($urandom);
            if (act == ACT_CAPTURE) begin
               r = $urandom_range(0, 99);
               if (r < 60)
                  p = FIELD_W'($urandom_range(lo, hi));
               else if (r < 70)
                  p = lo;
               else if (r < 80)
                  p = hi;
               else if (r < 85)
                  p = lo - 16'd1;
               else if (r < 90)
                  p = hi + 16'd1;
               r = $urandom_range(0, 99);
               if (r < 70)
                  h = FIELD_W'($urandom_range(0, p));
               else if (r < 78)
                  h = p;
               else if (r < 84)
                  h = p + 16'd1;
               else if (r < 90)
                  h = '0;
            end
            send_word(act, p, h, 1'b0, NO_READING);
            if (act != ACT_NONE)
               n++;
         end
      end

      settle_block();
      if (expected_readings.size() != 0) begin
         $error("%0d reading words never arrived", expected_readings.size());
         mismatches++;
      end
      $display("Covered %0d ticks, %0d captures (%0d kept) and %0d reads over %0d settings.",
               tick_words, capture_words, kept_count, read_words, PHASES + 1);
      $display("Checked %0d reading words, with one long response hold-off.",
               readings_checked);
      if (mismatches == 0)
         $display("pwm_rssi_duty_monitor verification clean");
      else
         $display("pwm_rssi_duty_monitor verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/prdm_pkg.sv
hdl/prdm_req_if.sv
hdl/prdm_rsp_if.sv
hdl/prdm_ctrl.sv
hdl/prdm_dp.sv
hdl/pwm_rssi_duty_monitor.sv
test/tb_pwm_rssi_duty_monitor.sv
